/* hdl/assert_macros.svh */
// Assertion macros used by the module of the pattern scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* hdl/wbps_pkg.sv */
// Types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int ADDR_W            = 64;
    localparam int LEN_W             = 6;
    localparam int POS_W             = 6;
    localparam int BYTE_W            = 8;
    localparam int PATTERN_DEPTH     = 63;
    localparam int TABLE_DEPTH       = 256;
    localparam int TABLE_AW          = 8;
    localparam int MASK_BITS_DEFAULT = 64;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 64;
    localparam int KIND_W            = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS   = CFG_INDEX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_SCAN  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        LD_IDLE,
        LD_CLR,
        LD_SET
    } t_ld_state;

endpackage

/* hdl/wildcard_byte_pattern_scanner.sv */
// Shift-And byte pattern scanner with wildcards, built around a byte mask table memory.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | to block  | i_in_valid / o_in_ready    | kind, position, byte, wildcard, last, fault
//  out     | from block| o_out_valid / i_out_ready  | found, match_address
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | register index, write data
//
// Start and scan beats are taken one per cycle while no load is busy and the output buffer
// has room; a result is registered in the input stage and then in the output buffer.
// A load beat holds off input beats while in the input stage and, for a position in range,
// while it rewrites one or two rows of the 256-row byte mask table via its single write port.
// After reset a clearing pass zeroes all 256 rows of the table; no input beat is taken then.
// A two-entry output buffer lets input beats continue while a result waits to be taken.
`include "assert_macros.svh"

module wildcard_byte_pattern_scanner #(
    parameter int MASK_BITS = wbps_pkg::MASK_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [wbps_pkg::KIND_W-1:0]       i_kind,
    input  logic [wbps_pkg::POS_W-1:0]        i_position,
    input  logic [wbps_pkg::BYTE_W-1:0]       i_byte_value,
    input  logic                              i_is_wildcard,
    input  logic                              i_last_byte,
    input  logic                              i_read_fault,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [wbps_pkg::ADDR_W-1:0]       o_match_address,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wbps_pkg::*;

    logic [PATTERN_DEPTH-1:0] r_table [TABLE_DEPTH];
    logic [BYTE_W-1:0]        r_pattern [PATTERN_DEPTH];

    logic [LEN_W-1:0]         r_len;
    logic [ADDR_W-1:0]        r_base;
    logic [ADDR_W-1:0]        r_base_adj;

    logic                     r_s1_valid;
    t_kind                    r_s1_kind;
    logic [POS_W-1:0]         r_s1_pos;
    logic [BYTE_W-1:0]        r_s1_byte;
    logic                     r_s1_wild;
    logic                     r_s1_last;
    logic                     r_s1_fault;

    logic [BYTE_W-1:0]        r_pat_q;
    logic [PATTERN_DEPTH-1:0] r_tbl_q;

    logic [PATTERN_DEPTH-1:0] r_wild, n_wild;
    logic [MASK_BITS-1:0]     r_mv, n_mv;
    logic [ADDR_W-1:0]        r_offset, n_offset;
    logic                     r_finished, n_finished;

    t_ld_state                r_ld_state, n_ld_state;
    logic [POS_W-1:0]         r_ld_pos;
    logic [BYTE_W-1:0]        r_ld_byte;
    logic [BYTE_W-1:0]        r_ld_old;

    logic [TABLE_AW-1:0]      r_clr_idx;
    logic                     r_clr_done;

    logic                     r_ob_found [2];
    logic [ADDR_W-1:0]        r_ob_addr [2];
    logic                     r_rd_ptr;
    logic                     r_wr_ptr;
    logic [1:0]               r_count;

    logic                     in_accept;
    logic                     out_pop;
    logic                     busy;
    logic                     s1_may_push;
    logic [2:0]               occupancy;
    logic [LEN_W-1:0]         len_eff;
    logic                     len_too_long;
    logic [PATTERN_DEPTH-1:0] pos_ok;
    logic [ADDR_W-1:0]        ok_ext;
    logic [MASK_BITS-1:0]     mv_shift;
    logic [MASK_BITS-1:0]     mv_new;
    logic                     hit;
    logic                     push;
    logic                     push_found;
    logic [ADDR_W-1:0]        push_addr;
    logic                     ld_start;
    logic                     tbl_we;
    logic [TABLE_AW-1:0]      tbl_waddr;
    logic [PATTERN_DEPTH-1:0] tbl_wdata;
    logic [TABLE_AW-1:0]      tbl_raddr;
    logic [PATTERN_DEPTH-1:0] ld_bit;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 2'd0);
    assign out_pop     = o_out_valid && i_out_ready;
    assign o_found         = r_ob_found[r_rd_ptr];
    assign o_match_address = r_ob_addr[r_rd_ptr];

    assign busy = !r_clr_done || (r_s1_valid && (r_s1_kind == KIND_LOAD))
                  || (r_ld_state != LD_IDLE);
    assign s1_may_push = r_s1_valid && (r_s1_kind == KIND_SCAN);
    assign occupancy   = 3'(r_count) - 3'(out_pop) + 3'(s1_may_push);
    assign o_in_ready  = !busy && (occupancy < 3'd2);

    assign len_eff      = (r_len == '0) ? LEN_W'(1) : r_len;
    assign len_too_long = ({1'b0, len_eff} >= (LEN_W + 1)'(MASK_BITS));

    always_comb begin
        for (int k = 0; k < PATTERN_DEPTH; k++) begin
            pos_ok[k] = (r_tbl_q[k] || r_wild[k]) && (LEN_W'(k) < len_eff);
        end
    end

    assign ok_ext   = {pos_ok, 1'b0};
    assign mv_shift = {r_mv[MASK_BITS-2:1], 2'b10};
    assign mv_new   = mv_shift & ok_ext[MASK_BITS-1:0];
    assign hit      = ((mv_new >> len_eff) != '0);

    always_comb begin
        n_mv       = r_mv;
        n_offset   = r_offset;
        n_finished = r_finished;
        n_wild     = r_wild;
        push       = 1'b0;
        push_found = 1'b0;
        push_addr  = '0;
        ld_start   = 1'b0;
        if (r_s1_valid) begin
            unique case (r_s1_kind)
                KIND_LOAD: begin
                    if (r_s1_pos < POS_W'(PATTERN_DEPTH)) begin
                        n_wild[r_s1_pos] = r_s1_wild;
                        ld_start         = 1'b1;
                    end
                end
                KIND_START: begin
                    n_mv       = '0;
                    n_offset   = '0;
                    n_finished = 1'b0;
                end
                KIND_SCAN: begin
                    if (!r_finished) begin
                        if (r_s1_fault || len_too_long) begin
                            n_finished = 1'b1;
                            push       = 1'b1;
                        end else begin
                            n_mv     = mv_new;
                            n_offset = r_offset + ADDR_W'(1);
                            if (hit) begin
                                n_finished = 1'b1;
                                push       = 1'b1;
                                push_found = 1'b1;
                                push_addr  = r_base_adj + r_offset;
                            end else if (r_s1_last) begin
                                n_finished = 1'b1;
                                push       = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign ld_bit = PATTERN_DEPTH'(1) << r_ld_pos;

    always_comb begin
        n_ld_state = r_ld_state;
        tbl_we     = 1'b0;
        tbl_waddr  = r_ld_old;
        tbl_wdata  = r_tbl_q;
        tbl_raddr  = i_byte_value;
        if (!r_clr_done) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr_idx;
            tbl_wdata = '0;
        end else begin
            unique case (r_ld_state)
                LD_IDLE: begin
                    if (ld_start) begin
                        tbl_raddr  = r_pat_q;
                        n_ld_state = LD_CLR;
                    end
                end
                LD_CLR: begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_ld_old;
                    if (r_ld_old == r_ld_byte) begin
                        tbl_wdata  = r_tbl_q | ld_bit;
                        n_ld_state = LD_IDLE;
                    end else begin
                        tbl_wdata  = r_tbl_q & ~ld_bit;
                        tbl_raddr  = r_ld_byte;
                        n_ld_state = LD_SET;
                    end
                end
                LD_SET: begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = r_ld_byte;
                    tbl_wdata  = r_tbl_q | ld_bit;
                    n_ld_state = LD_IDLE;
                end
                default: begin
                    n_ld_state = LD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_q <= r_table[tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (i_kind == KIND_LOAD) && (i_position < POS_W'(PATTERN_DEPTH))) begin
            r_pattern[i_position] <= i_byte_value;
        end
        r_pat_q <= r_pattern[i_position];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_state <= LD_IDLE;
        end else begin
            r_ld_state <= n_ld_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_start) begin
            r_ld_pos  <= r_s1_pos;
            r_ld_byte <= r_s1_byte;
            r_ld_old  <= r_pat_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            r_clr_idx <= r_clr_idx + TABLE_AW'(1);
            if (r_clr_idx == TABLE_AW'(TABLE_DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(1);
            r_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_PATTERN_LENGTH) begin
                r_len <= i_cfg_data[LEN_W-1:0];
            end else if (i_cfg_index == CFG_BASE_ADDRESS) begin
                r_base <= i_cfg_data[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_adj <= r_base - ADDR_W'(len_eff) + ADDR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind  <= t_kind'(i_kind);
            r_s1_pos   <= i_position;
            r_s1_byte  <= i_byte_value;
            r_s1_wild  <= i_is_wildcard;
            r_s1_last  <= i_last_byte;
            r_s1_fault <= i_read_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wild     <= '0;
            r_mv       <= '0;
            r_offset   <= '0;
            r_finished <= 1'b1;
        end else begin
            r_wild     <= n_wild;
            r_mv       <= n_mv;
            r_offset   <= n_offset;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ob_found[r_wr_ptr] <= push_found;
            r_ob_addr[r_wr_ptr]  <= push_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (out_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(out_pop);
        end
    end

    `ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n, !r_clr_done, !o_in_ready)
    `ASSERT_SAME(a_scan_not_during_load, i_clk, i_rst_n, s1_may_push, r_ld_state == LD_IDLE)
    `ASSERT_SAME(a_buffer_has_room, i_clk, i_rst_n, push, (r_count < 2'd2) || out_pop)
    `ASSERT_NEXT(a_done_after_result, i_clk, i_rst_n, push, r_finished)

endmodule

/* bench/wildcard_byte_pattern_scanner_tb.sv */
// Self-checking testbench for the wildcard byte pattern scanner with a class-based scoreboard.
module wildcard_byte_pattern_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wbps_pkg::*;

    localparam int MASK_BITS     = MASK_BITS_DEFAULT;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BEATS  = 1250;
    localparam int QUIET_TAIL    = 200;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [POS_W-1:0] POS_OUT_OF_RANGE = 6'd63;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_scan_result;

    class scan_scoreboard;
        logic [BYTE_W-1:0] pat [PATTERN_DEPTH];
        logic [PATTERN_DEPTH-1:0] wild_bits;
        logic [63:0] match_bits;
        logic [63:0] offset;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0] plen;
        bit done;
        t_scan_result expected_q[$];
        int mismatches;
        int found_count;
        int miss_count;

        function new();
            for (int k = 0; k < PATTERN_DEPTH; k++) pat[k] = '0;
            wild_bits = '0;
            match_bits = '0;
            offset = '0;
            base = '0;
            plen = LEN_W'(1);
            done = 1'b1;
            mismatches = 0;
            found_count = 0;
            miss_count = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PATTERN_LENGTH) plen = data[LEN_W-1:0];
            else if (idx == CFG_BASE_ADDRESS) base = data;
        endfunction

        function void note_input(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                 logic [BYTE_W-1:0] b, logic wild, logic last, logic fault);
            logic [63:0] accept;
            int len;
            int k;
            t_scan_result r;
            if (kind == KIND_LOAD) begin
                if (pos < PATTERN_DEPTH) begin
                    pat[pos] = b;
                    wild_bits[pos] = wild;
                end
                return;
            end
            if (kind == KIND_START) begin
                match_bits = '0;
                offset = '0;
                done = 1'b0;
                return;
            end
            if (kind != KIND_SCAN || done) return;
            len = (plen == 0) ? 1 : int'(plen);
            if (fault || len >= MASK_BITS) begin
                done = 1'b1;
                r.found = 1'b0;
                r.addr = '0;
                expected_q.push_back(r);
                return;
            end
            accept = '0;
            for (k = 0; k < len && k < PATTERN_DEPTH; k++) begin
                if (wild_bits[k] || pat[k] == b) accept[k+1] = 1'b1;
            end
            match_bits = ((match_bits | 64'd1) << 1) & accept;
            if ((match_bits >> len) != 0) begin
                done = 1'b1;
                r.found = 1'b1;
                r.addr = base + offset - 64'(len) + 64'd1;
                expected_q.push_back(r);
                offset = offset + 64'd1;
                return;
            end
            offset = offset + 64'd1;
            if (last) begin
                done = 1'b1;
                r.found = 1'b0;
                r.addr = '0;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(logic found, logic [ADDR_W-1:0] addr);
            t_scan_result e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result found=%b address=%h", found, addr);
                return;
            end
            e = expected_q.pop_front();
            if (found !== e.found || addr !== e.addr) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result found=%b address=%h, expected found=%b address=%h",
                             found, addr, e.found, e.addr);
            end else if (e.found) begin
                found_count++;
            end else begin
                miss_count++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [KIND_W-1:0]      i_kind;
    logic [POS_W-1:0]       i_position;
    logic [BYTE_W-1:0]      i_byte_value;
    logic                   i_is_wildcard;
    logic                   i_last_byte;
    logic                   i_read_fault;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_found;
    logic [ADDR_W-1:0]      o_match_address;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    scan_scoreboard sb;
    bit gaps_on;
    int hold_request;
    int stall_cycles;
    int beats_in;
    int reg_writes;

    wildcard_byte_pattern_scanner #(
        .MASK_BITS(MASK_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .i_byte_value   (i_byte_value),
        .i_is_wildcard  (i_is_wildcard),
        .i_last_byte    (i_last_byte),
        .i_read_fault   (i_read_fault),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_match_address(o_match_address),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_found, o_match_address);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // The receiver stalls in random bursts and once for a long stretch on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                i_out_ready = 1'b0;
                repeat (hold_request) @(negedge i_clk);
                hold_request = 0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                             input logic [BYTE_W-1:0] b, input logic wild,
                             input logic last, input logic fault);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_kind = kind;
        i_position = pos;
        i_byte_value = b;
        i_is_wildcard = wild;
        i_last_byte = last;
        i_read_fault = fault;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(kind, pos, b, wild, last, fault);
        beats_in++;
        @(negedge i_clk);
    endtask

    task automatic load_pos(input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] b,
                            input logic wild);
        send_beat(KIND_LOAD, pos, b, wild, 1'($urandom), 1'($urandom));
    endtask

    task automatic start_scan();
        send_beat(KIND_START, POS_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                  1'($urandom), 1'($urandom));
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last, input logic fault);
        send_beat(KIND_SCAN, POS_W'($urandom), b, 1'($urandom), last, fault);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_directed();
        // Scan before any start, unused kind and out-of-range load: all ignored.
        scan_byte(8'hA5, 1'b1, 1'b0);
        send_beat(KIND_UNUSED, 6'd0, 8'h00, 1'b0, 1'b1, 1'b1);
        load_pos(POS_OUT_OF_RANGE, 8'hFF, 1'b1);
        for (int k = 0; k < PATTERN_DEPTH; k++)
            load_pos(POS_W'(k), BYTE_W'($urandom), $urandom_range(0, 4) == 0);
        settle();
        // Length zero behaves as one; the match address wraps past the top.
        write_reg(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0);
        write_reg(CFG_BASE_ADDRESS, '1);
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
        load_pos(6'd0, 8'hFF, 1'b0);
        start_scan();
        scan_byte(8'h00, 1'b0, 1'b0);
        scan_byte(8'hFF, 1'b0, 1'b0);
        scan_byte(8'hFF, 1'b1, 1'b0);
        start_scan();
        scan_byte(8'hFF, 1'b0, 1'b1);
        start_scan();
        scan_byte(8'h12, 1'b1, 1'b0);
        start_scan();
        scan_byte(8'hFF, 1'b1, 1'b0);
        load_pos(6'd0, 8'h00, 1'b1);
        start_scan();
        scan_byte(8'h00, 1'b1, 1'b0);
        settle();
    endtask

    // Short scans under a long receiver stall so that the block backs up into its input.
    task automatic run_pressure();
        write_reg(CFG_PATTERN_LENGTH, 64'd1);
        write_reg(CFG_BASE_ADDRESS, {$urandom, $urandom});
        load_pos(6'd0, 8'h5A, 1'b0);
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 40; n++) begin
            start_scan();
            scan_byte(8'h5A, 1'b0, 1'b0);
        end
        settle();
    endtask

    task automatic run_session(input int len_sel);
        logic [BYTE_W-1:0] data_buf [0:199];
        logic [ADDR_W-1:0] base;
        int eff;
        int region;
        int plant_at;
        int nscans;
        bit narrow;
        settle();
        eff = (len_sel == 0) ? 1 : len_sel;
        narrow = $urandom_range(0, 2) != 0;
        case ($urandom_range(0, 4))
            0: base = '0;
            1: base = '1;
            2: base = '1 - 64'($urandom_range(0, 40));
            default: base = {$urandom, $urandom};
        endcase
        write_reg(CFG_PATTERN_LENGTH, {$urandom, $urandom} & ~64'h3F | 64'(len_sel));
        write_reg(CFG_BASE_ADDRESS, base);
        for (int k = 0; k < eff; k++)
            load_pos(POS_W'(k), narrow ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom),
                     $urandom_range(0, 4) == 0);
        nscans = $urandom_range(1, 4);
        for (int s = 0; s < nscans; s++) begin
            if ($urandom_range(0, 3) == 0) scan_byte(BYTE_W'($urandom), 1'($urandom), 1'b0);
            start_scan();
            region = $urandom_range(1, 2 * eff + 8);
            for (int i = 0; i < region; i++)
                data_buf[i] = narrow ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom);
            if ($urandom_range(0, 2) != 0 && region >= eff) begin
                plant_at = $urandom_range(0, region - eff);
                for (int k = 0; k < eff; k++)
                    data_buf[plant_at + k] = sb.wild_bits[k] ? BYTE_W'($urandom) : sb.pat[k];
            end
            for (int i = 0; i < region; i++) begin
                case ($urandom_range(0, 59))
                    0: send_beat(KIND_UNUSED, POS_W'($urandom), BYTE_W'($urandom),
                                 1'($urandom), 1'($urandom), 1'($urandom));
                    1: load_pos(POS_OUT_OF_RANGE, BYTE_W'($urandom), 1'($urandom));
                    2: load_pos(POS_W'($urandom_range(0, PATTERN_DEPTH - 1)),
                                BYTE_W'($urandom), 1'($urandom));
                    default: ;
                endcase
                scan_byte(data_buf[i], i == region - 1 && $urandom_range(0, 5) != 0,
                          $urandom_range(0, 29) == 0);
            end
        end
    endtask

    initial begin
        int first_random;
        int len_sel;
        sb = new();
        gaps_on = 1'b1;
        hold_request = 0;
        stall_cycles = 0;
        beats_in = 0;
        reg_writes = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = KIND_LOAD;
        i_position = '0;
        i_byte_value = '0;
        i_is_wildcard = 1'b0;
        i_last_byte = 1'b0;
        i_read_fault = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PATTERN_LENGTH;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_pressure();
        first_random = beats_in;
        run_session(PATTERN_DEPTH);
        while (beats_in - first_random < RANDOM_BEATS) begin
            if (beats_in - first_random > RANDOM_BEATS - QUIET_TAIL) gaps_on = 1'b0;
            len_sel = ($urandom_range(0, 9) == 0) ? $urandom_range(20, PATTERN_DEPTH)
                                                   : $urandom_range(0, 8);
            run_session(len_sel);
        end
        gaps_on = 1'b0;
        settle();
        repeat (20) @(negedge i_clk);

        $display("Summary: %0d input beats and %0d register writes, lengths 0 to 63, wrapping bases.",
                 beats_in, reg_writes);
        $display("Summary: %0d matches and %0d not-found results checked, %0d mismatches.",
                 sb.found_count, sb.miss_count, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
